@@ rtl/core/tild_pkg.sv @@
// tild_pkg: shared types and constants for the tty input line discipline unit
// transaction structs, register indexes, mode flag bits and state codes
// no dependencies
`timescale 1ns / 1ps

package tild_pkg;

  localparam int STORE_DEPTH_DEFAULT = 1024;

  localparam int NUM_REGS  = 8;
  localparam int REG_AW    = 3;
  localparam int PADDR_W   = REG_AW + 2;

  // register indexes
  localparam logic [REG_AW-1:0] REG_MODE      = 3'd0;
  localparam logic [REG_AW-1:0] REG_INTERRUPT = 3'd1;
  localparam logic [REG_AW-1:0] REG_QUIT      = 3'd2;
  localparam logic [REG_AW-1:0] REG_ERASE     = 3'd3;
  localparam logic [REG_AW-1:0] REG_KILL      = 3'd4;
  localparam logic [REG_AW-1:0] REG_EOF       = 3'd5;
  localparam logic [REG_AW-1:0] REG_RESUME    = 3'd6;
  localparam logic [REG_AW-1:0] REG_PAUSE     = 3'd7;

  // mode flag bits
  localparam int FL_CR_TO_NL    = 0;
  localparam int FL_DROP_CR     = 1;
  localparam int FL_NL_TO_CR    = 2;
  localparam int FL_LOWERCASE   = 3;
  localparam int FL_CANONICAL   = 4;
  localparam int FL_SIGNALS     = 5;
  localparam int FL_ECHO        = 6;
  localparam int FL_ECHO_CTRL   = 7;

  localparam logic [7:0] RESET_MODE      = 8'd241;
  localparam logic [7:0] RESET_INTERRUPT = 8'd3;
  localparam logic [7:0] RESET_QUIT      = 8'd28;
  localparam logic [7:0] RESET_ERASE     = 8'd127;
  localparam logic [7:0] RESET_KILL      = 8'd21;
  localparam logic [7:0] RESET_EOF       = 8'd4;
  localparam logic [7:0] RESET_RESUME    = 8'd17;
  localparam logic [7:0] RESET_PAUSE     = 8'd19;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_CARET = 8'd94;
  localparam logic [7:0] CH_UPA   = 8'd65;
  localparam logic [7:0] CH_UPZ   = 8'd90;
  localparam logic [7:0] CASE_OFS = 8'd32;
  localparam logic [7:0] CTRL_OFS = 8'd64;

  localparam logic [9:0]  LINE_MAX   = 10'd1023;
  localparam logic [11:0] RUBOUT_MAX = 12'd4095;

  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  localparam logic [1:0] SIG_NONE      = 2'd0;
  localparam logic [1:0] SIG_INTERRUPT = 2'd1;
  localparam logic [1:0] SIG_QUIT      = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  echo_count;
    logic [7:0]  echo_first;
    logic [7:0]  echo_second;
    logic [11:0] rubout_count;
    logic [1:0]  signal_raised;
    logic        output_stopped;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic [9:0]  lines_ready;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_KILL,
    S_EMIT
  } state_t;

endpackage

@@ rtl/core/tty_input_line_discipline_unit.sv @@
// tty_input_line_discipline_unit: canonical terminal input path around a line store memory
// depends on tild_pkg
// an input transaction is registered along with the line store read, then evaluated and its result registered
// a new transaction is taken only once the last one is done (memory read, then evaluate and write back)
// a kill walks back through the line store, one entry per cycle
// a result waiting on out_stall holds the unit until it is taken
// reset: synchronous, clears indices, line count, stopped flag and loads register defaults;
// the line store is not cleared, only occupied entries are ever read
`timescale 1ns / 1ps

module tty_input_line_discipline_unit #(
  parameter int STORE_DEPTH = tild_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tild_pkg::in_t              in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tild_pkg::out_t             out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tild_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  import tild_pkg::*;

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  // configuration registers
  logic [7:0] regs [NUM_REGS];

  assign pready = 1'b1;
  assign prdata = {24'd0, regs[paddr[PADDR_W-1:2]]};

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_MODE]      <= RESET_MODE;
      regs[REG_INTERRUPT] <= RESET_INTERRUPT;
      regs[REG_QUIT]      <= RESET_QUIT;
      regs[REG_ERASE]     <= RESET_ERASE;
      regs[REG_KILL]      <= RESET_KILL;
      regs[REG_EOF]       <= RESET_EOF;
      regs[REG_RESUME]    <= RESET_RESUME;
      regs[REG_PAUSE]     <= RESET_PAUSE;
    end else if (psel && penable && pwrite && pready) begin
      regs[paddr[PADDR_W-1:2]] <= pwdata[7:0];
    end
  end

  logic [7:0] mode;
  assign mode = regs[REG_MODE];

  // line store
  logic [7:0]       line_store [STORE_DEPTH];
  logic [IDX_W-1:0] mem_raddr;
  logic [7:0]       mem_q;
  logic             mem_we;

  // control and working state
  state_t           state, state_next;
  logic [IDX_W-1:0] write_index, write_index_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [9:0]       line_count, line_count_next;
  logic             stopped, stopped_next;
  logic [11:0]      rub, rub_next;
  out_t             res, res_next;
  logic             load_out;

  logic             op_q;
  logic [7:0]       c_q;
  logic             keep_q;
  logic             avail_q;

  // input mapping at acceptance
  logic [7:0] c_map;
  logic       keep_map;
  logic       accept_in;

  assign in_stall  = (state != S_IDLE);
  assign accept_in = in_valid && !in_stall;

  always_comb begin
    c_map    = in_item.rx_byte;
    keep_map = 1'b1;
    if (in_item.rx_byte == CH_CR) begin
      if (mode[FL_CR_TO_NL]) c_map = CH_NL;
      else if (mode[FL_DROP_CR]) keep_map = 1'b0;
    end else if (in_item.rx_byte == CH_NL && mode[FL_NL_TO_CR]) begin
      c_map = CH_CR;
    end
    if (mode[FL_LOWERCASE] && c_map >= CH_UPA && c_map <= CH_UPZ) begin
      c_map = c_map + CASE_OFS;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      op_q    <= in_item.operation;
      c_q     <= c_map;
      keep_q  <= keep_map;
      avail_q <= (in_item.operation == OP_READ) ? (write_index != read_index)
                                                : (idx_next(write_index) != read_index);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[write_index] <= c_q;
    end
    mem_q <= line_store[mem_raddr];
  end

  // one erase step on the byte before write_index (held in mem_q)
  logic        can_erase;
  logic [1:0]  rub_inc;
  logic [12:0] rub_sum;
  logic [11:0] rub_sat;
  logic [11:0] rub_base;

  always_comb begin
    can_erase = (write_index != read_index) && (mem_q != CH_NL) && (mem_q != regs[REG_EOF]);
    rub_inc   = !mode[FL_ECHO] ? 2'd0 : ((mem_q < CH_SPACE) ? 2'd2 : 2'd1);
    rub_base  = (state == S_KILL) ? rub : 12'd0;
    rub_sum   = {1'b0, rub_base} + {11'd0, rub_inc};
    rub_sat   = (rub_sum > {1'b0, RUBOUT_MAX}) ? RUBOUT_MAX : rub_sum[11:0];
  end

  always_comb begin
    logic store;
    logic emit;
    logic [7:0] rb;
    store            = 1'b0;
    emit             = 1'b0;
    rb               = mem_q;
    state_next       = state;
    write_index_next = write_index;
    read_index_next  = read_index;
    line_count_next  = line_count;
    stopped_next     = stopped;
    rub_next         = rub;
    mem_we           = 1'b0;
    load_out         = 1'b0;
    res_next         = '0;
    mem_raddr        = idx_prev(write_index);

    unique case (state)
      S_IDLE: begin
        mem_raddr = (in_item.operation == OP_READ) ? read_index : idx_prev(write_index);
        if (accept_in) state_next = S_EVAL;
      end

      S_EVAL: begin
        emit = 1'b1;
        if (op_q == OP_READ) begin
          if (avail_q) begin
            res_next.read_valid = 1'b1;
            res_next.read_byte  = rb;
            read_index_next     = idx_next(read_index);
            if ((rb == CH_NL || rb == regs[REG_EOF]) && line_count != 10'd0) begin
              line_count_next = line_count - 10'd1;
            end
          end
        end else if (avail_q) begin
          res_next.accepted = 1'b1;
          store = keep_q;
          if (store && mode[FL_CANONICAL]) begin
            if (c_q == regs[REG_KILL]) begin
              store = 1'b0;
              if (can_erase) begin
                emit             = 1'b0;
                write_index_next = idx_prev(write_index);
                rub_next         = rub_sat;
                state_next       = S_KILL;
              end
            end else if (c_q == regs[REG_ERASE]) begin
              store = 1'b0;
              if (can_erase) begin
                write_index_next      = idx_prev(write_index);
                res_next.rubout_count = {10'd0, rub_inc};
              end
            end else if (c_q == regs[REG_PAUSE]) begin
              store        = 1'b0;
              stopped_next = 1'b1;
            end else if (c_q == regs[REG_RESUME]) begin
              store        = 1'b0;
              stopped_next = 1'b0;
            end
          end
          if (store && mode[FL_SIGNALS]) begin
            if (c_q == regs[REG_INTERRUPT]) begin
              store                  = 1'b0;
              res_next.signal_raised = SIG_INTERRUPT;
            end else if (c_q == regs[REG_QUIT]) begin
              store                  = 1'b0;
              res_next.signal_raised = SIG_QUIT;
            end
          end
          if (store) begin
            if ((c_q == CH_NL || c_q == regs[REG_EOF]) && line_count < LINE_MAX) begin
              line_count_next = line_count + 10'd1;
            end
            if (mode[FL_ECHO]) begin
              if (c_q == CH_NL) begin
                res_next.echo_count  = 2'd2;
                res_next.echo_first  = CH_NL;
                res_next.echo_second = CH_CR;
              end else if (c_q < CH_SPACE) begin
                if (mode[FL_ECHO_CTRL]) begin
                  res_next.echo_count  = 2'd2;
                  res_next.echo_first  = CH_CARET;
                  res_next.echo_second = c_q + CTRL_OFS;
                end
              end else begin
                res_next.echo_count = 2'd1;
                res_next.echo_first = c_q;
              end
            end
            mem_we           = 1'b1;
            write_index_next = idx_next(write_index);
          end
        end
      end

      S_KILL: begin
        res_next.accepted = 1'b1;
        if (can_erase) begin
          write_index_next = idx_prev(write_index);
          rub_next         = rub_sat;
        end else begin
          emit                  = 1'b1;
          res_next.rubout_count = rub;
        end
      end

      S_EMIT: begin
        res_next = res;
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // next read follows the index as it will stand after this cycle
    if (state != S_IDLE) mem_raddr = idx_prev(write_index_next);

    if (emit) begin
      res_next.output_stopped = stopped_next;
      res_next.lines_ready    = line_count_next;
      if (!out_valid || !out_stall) begin
        load_out   = 1'b1;
        state_next = S_IDLE;
      end else begin
        state_next = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_index <= '0;
      read_index  <= '0;
      line_count  <= '0;
      stopped     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      write_index <= write_index_next;
      read_index  <= read_index_next;
      line_count  <= line_count_next;
      stopped     <= stopped_next;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rub <= rub_next;
    res <= res_next;
    if (load_out) out_item <= res_next;
  end

endmodule

@@ tb/tild_line_checker.sv @@
// tild_line_checker: watches the input, result and register ports of the line discipline unit,
// predicts every result from its own copy of the line store and registers, and counts mismatches
// depends on tild_pkg
`timescale 1ns / 1ps

module tild_line_checker #(
  parameter int STORE_DEPTH = tild_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  tild_pkg::in_t                in_item,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  tild_pkg::out_t               out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [tild_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output int                           fail_count,
  output int                           pending,
  output int                           stored_bytes
);

  import tild_pkg::*;

  logic [7:0] regs [NUM_REGS];
  logic [7:0] line_mem [STORE_DEPTH];
  int         wr_ptr;
  int         rd_ptr;
  logic [9:0] lines;
  logic       stopped;
  out_t       predicted_results [$];
  int         mismatches = 0;

  function automatic int ptr_next(int p);
    return (p == STORE_DEPTH - 1) ? 0 : p + 1;
  endfunction

  function automatic int ptr_prev(int p);
    return (p == 0) ? STORE_DEPTH - 1 : p - 1;
  endfunction

  // drops the newest stored byte unless it ends a line; -1 when nothing was dropped
  function automatic int erase_last();
    logic [7:0] last;
    if (wr_ptr == rd_ptr) return -1;
    last = line_mem[ptr_prev(wr_ptr)];
    if (last == CH_NL || last == regs[REG_EOF]) return -1;
    wr_ptr = ptr_prev(wr_ptr);
    if (!regs[REG_MODE][FL_ECHO]) return 0;
    return (last < CH_SPACE) ? 2 : 1;
  endfunction

  function automatic out_t cook_key(in_t it);
    out_t       r;
    logic [7:0] mode;
    logic [7:0] c;
    logic       keep;
    int         rub;
    int         n;
    r    = '0;
    mode = regs[REG_MODE];
    c    = it.rx_byte;
    rub  = 0;
    if (it.operation == OP_READ) begin
      if (wr_ptr != rd_ptr) begin
        r.read_valid = 1'b1;
        r.read_byte  = line_mem[rd_ptr];
        rd_ptr       = ptr_next(rd_ptr);
        if ((r.read_byte == CH_NL || r.read_byte == regs[REG_EOF]) && lines != 0) lines--;
      end
    end else if (ptr_next(wr_ptr) != rd_ptr) begin
      r.accepted = 1'b1;
      keep       = 1'b1;
      if (c == CH_CR) begin
        if (mode[FL_CR_TO_NL]) c = CH_NL;
        else if (mode[FL_DROP_CR]) keep = 1'b0;
      end else if (c == CH_NL && mode[FL_NL_TO_CR]) begin
        c = CH_CR;
      end
      if (keep && mode[FL_LOWERCASE] && c >= CH_UPA && c <= CH_UPZ) c = c + CASE_OFS;
      if (keep && mode[FL_CANONICAL]) begin
        if (c == regs[REG_KILL]) begin
          n = erase_last();
          while (n >= 0) begin
            rub = rub + n;
            if (rub > RUBOUT_MAX) rub = RUBOUT_MAX;
            n = erase_last();
          end
          keep = 1'b0;
        end else if (c == regs[REG_ERASE]) begin
          n    = erase_last();
          rub  = (n < 0) ? 0 : n;
          keep = 1'b0;
        end else if (c == regs[REG_PAUSE]) begin
          stopped = 1'b1;
          keep    = 1'b0;
        end else if (c == regs[REG_RESUME]) begin
          stopped = 1'b0;
          keep    = 1'b0;
        end
      end
      if (keep && mode[FL_SIGNALS]) begin
        if (c == regs[REG_INTERRUPT]) begin
          r.signal_raised = SIG_INTERRUPT;
          keep            = 1'b0;
        end else if (c == regs[REG_QUIT]) begin
          r.signal_raised = SIG_QUIT;
          keep            = 1'b0;
        end
      end
      if (keep) begin
        if ((c == CH_NL || c == regs[REG_EOF]) && lines != LINE_MAX) lines++;
        if (mode[FL_ECHO]) begin
          if (c == CH_NL) begin
            r.echo_count  = 2'd2;
            r.echo_first  = CH_NL;
            r.echo_second = CH_CR;
          end else if (c < CH_SPACE) begin
            if (mode[FL_ECHO_CTRL]) begin
              r.echo_count  = 2'd2;
              r.echo_first  = CH_CARET;
              r.echo_second = c + CTRL_OFS;
            end
          end else begin
            r.echo_count = 2'd1;
            r.echo_first = c;
          end
        end
        line_mem[wr_ptr] = c;
        wr_ptr           = ptr_next(wr_ptr);
      end
    end
    r.rubout_count   = 12'(rub);
    r.output_stopped = stopped;
    r.lines_ready    = lines;
    return r;
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      regs[REG_MODE]      = RESET_MODE;
      regs[REG_INTERRUPT] = RESET_INTERRUPT;
      regs[REG_QUIT]      = RESET_QUIT;
      regs[REG_ERASE]     = RESET_ERASE;
      regs[REG_KILL]      = RESET_KILL;
      regs[REG_EOF]       = RESET_EOF;
      regs[REG_RESUME]    = RESET_RESUME;
      regs[REG_PAUSE]     = RESET_PAUSE;
      wr_ptr  = 0;
      rd_ptr  = 0;
      lines   = '0;
      stopped = 1'b0;
      predicted_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) regs[paddr[PADDR_W-1:2]] = pwdata[7:0];
      // compare before queuing this edge's input so a stray result cannot match it
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("result transaction with no prediction waiting");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(out_item.accepted));
          check_field("echo_count", 32'(want.echo_count), 32'(out_item.echo_count));
          check_field("echo_first", 32'(want.echo_first), 32'(out_item.echo_first));
          check_field("echo_second", 32'(want.echo_second), 32'(out_item.echo_second));
          check_field("rubout_count", 32'(want.rubout_count), 32'(out_item.rubout_count));
          check_field("signal_raised", 32'(want.signal_raised), 32'(out_item.signal_raised));
          check_field("output_stopped", 32'(want.output_stopped),
                      32'(out_item.output_stopped));
          check_field("read_valid", 32'(want.read_valid), 32'(out_item.read_valid));
          check_field("read_byte", 32'(want.read_byte), 32'(out_item.read_byte));
          check_field("lines_ready", 32'(want.lines_ready), 32'(out_item.lines_ready));
        end
      end
      if (in_valid && !in_stall) predicted_results.push_back(cook_key(in_item));
    end
    pending      <= predicted_results.size();
    stored_bytes <= (wr_ptr - rd_ptr + STORE_DEPTH) % STORE_DEPTH;
    fail_count   <= mismatches;
  end

endmodule

@@ tb/tb_top.sv @@
// tb_top: stimulus and verdict for tty_input_line_discipline_unit
// drives keystrokes, reads and register writes; checking is left to tild_line_checker
// depends on tild_pkg, tild_line_checker and the unit under test
`timescale 1ns / 1ps

module tb_top;
  import tild_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_item;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;
  int stored_bytes;

  logic [7:0] cfg [NUM_REGS];
  bit         tx_idle_en = 1'b1;
  bit         rx_idle_en = 1'b1;
  bit         quiet = 1'b0;
  int         cycle_count = 0;
  int         results_taken = 0;
  int         stall_left = 0;
  bit         long_hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tty_input_line_discipline_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tild_line_checker u_line_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .stored_bytes (stored_bytes)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold once 200 transactions are through
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) results_taken <= results_taken + 1;
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!long_hold_done && results_taken >= 200) begin
        out_stall      <= 1'b1;
        stall_left     <= 399;
        long_hold_done <= 1'b1;
      end else if (rx_idle_en && !quiet && $urandom_range(0, 4) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 10);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_t key(logic [7:0] b);
    in_t it;
    it.operation = OP_RECEIVE;
    it.rx_byte   = b;
    return it;
  endfunction

  function automatic in_t pop_req();
    in_t it;
    it.operation = OP_READ;
    it.rx_byte   = 8'($urandom);
    return it;
  endfunction

  // true for bytes other than cr, nl and the configured control characters
  function automatic bit is_plain(logic [7:0] b);
    if (b == CH_CR || b == CH_NL) return 1'b0;
    for (int i = 1; i < NUM_REGS; i++) begin
      if (b == cfg[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_code();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
  endfunction

  function automatic in_t random_key(int read_pct);
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < read_pct) return pop_req();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      do b = 8'($urandom); while (!is_plain(b));
    end else if (pick < 63) begin
      case ($urandom_range(0, 2))
        0: b = CH_CR;
        1: b = CH_NL;
        default: b = cfg[REG_EOF];
      endcase
    end else if (pick < 70) begin
      b = cfg[REG_ERASE];
    end else if (pick < 73) begin
      b = cfg[REG_KILL];
    end else if (pick < 77) begin
      b = $urandom_range(0, 1) ? cfg[REG_PAUSE] : cfg[REG_RESUME];
    end else if (pick < 81) begin
      b = $urandom_range(0, 1) ? cfg[REG_INTERRUPT] : cfg[REG_QUIT];
    end else if (pick < 89) begin
      b = 8'($urandom_range(0, 31));
    end else begin
      b = 8'($urandom);
    end
    return key(b);
  endfunction

  task automatic push_item(in_t it);
    if (tx_idle_en && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic configure(input logic [7:0] mode, intr, quit, erase, kill, eof, resume, pause);
    cfg[REG_MODE]      = mode;
    cfg[REG_INTERRUPT] = intr;
    cfg[REG_QUIT]      = quit;
    cfg[REG_ERASE]     = erase;
    cfg[REG_KILL]      = kill;
    cfg[REG_EOF]       = eof;
    cfg[REG_RESUME]    = resume;
    cfg[REG_PAUSE]     = pause;
    for (int i = 0; i < NUM_REGS; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'(4 * i);
      pwdata  <= {24'd0, cfg[i]};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(int count, int read_pct);
    tx_idle_en <= ($urandom_range(0, 3) != 0);
    rx_idle_en <= ($urandom_range(0, 3) != 0);
    repeat (count) push_item(random_key(read_pct));
    wait_drained();
  endtask

  initial begin
    logic [7:0] b;
    cfg[REG_MODE]      = RESET_MODE;
    cfg[REG_INTERRUPT] = RESET_INTERRUPT;
    cfg[REG_QUIT]      = RESET_QUIT;
    cfg[REG_ERASE]     = RESET_ERASE;
    cfg[REG_KILL]      = RESET_KILL;
    cfg[REG_EOF]       = RESET_EOF;
    cfg[REG_RESUME]    = RESET_RESUME;
    cfg[REG_PAUSE]     = RESET_PAUSE;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // register defaults, nothing written yet
    push_item(pop_req());
    push_item(key(8'h41));
    push_item(key(8'hFF));
    push_item(key(8'h01));
    push_item(key(8'h00));
    push_item(key(RESET_ERASE));
    push_item(key(CH_CR));
    push_item(key(RESET_ERASE));
    push_item(key(8'h62));
    push_item(key(RESET_KILL));
    push_item(key(RESET_KILL));
    push_item(key(RESET_EOF));
    push_item(key(RESET_INTERRUPT));
    push_item(key(RESET_QUIT));
    push_item(key(RESET_PAUSE));
    push_item(key(RESET_RESUME));
    repeat (6) push_item(pop_req());
    wait_drained();

    // drop cr, nl to cr, lowercase, echo without control echo, raw mode
    configure(8'h4E, RESET_INTERRUPT, RESET_QUIT, RESET_ERASE, RESET_KILL, RESET_EOF,
              RESET_RESUME, RESET_PAUSE);
    push_item(key(CH_CR));
    push_item(key(CH_NL));
    push_item(key(8'h5A));
    push_item(key(8'h1B));
    wait_drained();

    configure(RESET_MODE, RESET_INTERRUPT, RESET_QUIT, RESET_ERASE, RESET_KILL, RESET_EOF,
              RESET_RESUME, RESET_PAUSE);
    random_phase(200, 45);
    configure(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    random_phase(30, 45);
    configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    random_phase(30, 45);
    repeat (3) begin
      configure(8'($urandom), rand_code(), rand_code(), rand_code(), rand_code(), rand_code(),
                rand_code(), rand_code());
      random_phase(30, 45);
    end

    // empty the store, then one long unterminated line wiped by a single kill
    configure(RESET_MODE, RESET_INTERRUPT, RESET_QUIT, RESET_ERASE, RESET_KILL, RESET_EOF,
              RESET_RESUME, RESET_PAUSE);
    repeat (stored_bytes) push_item(pop_req());
    repeat (120) begin
      do b = 8'($urandom); while (!is_plain(b));
      push_item(key(b));
    end
    push_item(key(RESET_KILL));
    wait_drained();

    // fill the empty store with end-of-file bytes until it refuses
    configure(8'h00, RESET_INTERRUPT, RESET_QUIT, RESET_ERASE, RESET_KILL, RESET_EOF,
              RESET_RESUME, RESET_PAUSE);
    repeat (STORE_DEPTH_DEFAULT + 3) push_item(key(RESET_EOF));
    wait_drained();

    // stored bytes stop counting as line ends, so a new newline hits the line count ceiling
    configure(8'hD0, RESET_INTERRUPT, RESET_QUIT, RESET_ERASE, RESET_KILL, 8'd5,
              RESET_RESUME, RESET_PAUSE);
    push_item(pop_req());
    push_item(key(CH_NL));
    push_item(key(8'h71));
    push_item(key(RESET_KILL));
    push_item(pop_req());
    push_item(key(RESET_KILL));
    push_item(key(RESET_ERASE));
    wait_drained();

    quiet <= 1'b1;
    configure(8'($urandom) | 8'h10, RESET_INTERRUPT, RESET_QUIT, RESET_ERASE, RESET_KILL,
              RESET_EOF, RESET_RESUME, RESET_PAUSE);
    random_phase(80, 45);

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tild_pkg.sv
rtl/core/tty_input_line_discipline_unit.sv
tb/tild_line_checker.sv
tb/tb_top.sv
